[hw/rtl/qau_pkg.sv]
package qau_pkg;

    // Number format and derived widths.
    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * DATA_BITS;
    localparam int WIDE_BITS = 2 * DATA_BITS + 8;
    localparam int ROOT_BITS = DATA_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int QUO_BITS  = FRAC_BITS + 1;

    typedef logic signed [DATA_BITS-1:0] t_data;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [WIDE_BITS-1:0] t_wide;

    typedef enum logic [2:0] {
        CMD_MUL  = 3'd0,
        CMD_ROT  = 3'd1,
        CMD_NORM = 3'd2,
        CMD_CONJ = 3'd3,
        CMD_NEG  = 3'd4,
        CMD_LEN  = 3'd5,
        CMD_LSQ  = 3'd6
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        t_data val;
        logic  ovf;
    } t_sat;

    // One transaction as it moves through the root and divider stages.
    typedef struct packed {
        logic [2:0]                           cmd;
        logic                                 zero;
        logic                                 ovf;
        logic [3:0][DATA_BITS-1:0]            res;
        logic [RAD_BITS-1:0]                  rad;
        logic [ROOT_BITS:0]                   rem;
        logic [ROOT_BITS-1:0]                 root;
        logic [3:0]                           neg;
        logic [3:0][ROOT_BITS-1:0]            drem;
        logic [3:0][QUO_BITS-1:0]             dq;
    } t_item;

    function automatic t_wide wext_d(input t_data v);
        return {{(WIDE_BITS-DATA_BITS){v[DATA_BITS-1]}}, v};
    endfunction

    function automatic t_wide wext_p(input t_prod v);
        return {{(WIDE_BITS-PROD_BITS){v[PROD_BITS-1]}}, v};
    endfunction

    function automatic t_sat sat_wide(input t_wide v);
        t_wide hi;
        t_wide lo;
        t_sat  r;
        hi = {{(WIDE_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            r.val = hi[DATA_BITS-1:0];
            r.ovf = 1'b1;
        end else if (v < lo) begin
            r.val = lo[DATA_BITS-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[DATA_BITS-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat round_sat(input t_wide v);
        return sat_wide(v >>> FRAC_BITS);
    endfunction

    function automatic t_sat neg_sat(input t_data v);
        return sat_wide(-wext_d(v));
    endfunction

endpackage

[hw/rtl/qau_front.sv]
module qau_front import qau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [2:0] i_cmd,
    input  t_data      i_qa [4],
    input  t_data      i_qb [4],
    output logic       o_valid,
    output t_item      o_item
);

    typedef struct packed {
        logic [2:0]                cmd;
        logic                      zero;
        logic                      ovf;
        logic [3:0][DATA_BITS-1:0] res;
        logic [RAD_BITS-1:0]       s;
        logic [3:0][DATA_BITS-1:0] qa;
        logic [3:0][DATA_BITS-1:0] qb;
        logic [2:0][DATA_BITS-1:0] c1;
    } t_carry;

    // Stage 1: all sixteen pairwise products of A and B, and the squares of A.
    logic       r1_valid;
    logic [2:0] r1_cmd;
    t_data      r1_qa [4];
    t_data      r1_qb [4];
    t_prod      r1_pm [4][4];
    t_prod      r1_sq [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_cmd;
            for (int i = 0; i < 4; i++) begin
                r1_qa[i] <= i_qa[i];
                r1_qb[i] <= i_qb[i];
                r1_sq[i] <= i_qa[i] * i_qa[i];
                for (int j = 0; j < 4; j++) begin
                    r1_pm[i][j] <= i_qa[i] * i_qb[j];
                end
            end
        end
    end

    // Stage 2: Hamilton sums, first cross product, unary ops, sum of squares.
    t_sat                ham [4];
    t_sat                c1s [3];
    t_sat                nq [4];
    t_sat                lsq;
    logic [RAD_BITS-1:0] ssum;
    t_carry              n2_c;
    t_carry              r2_c;
    logic                r2_valid;

    always_comb begin
        ham[0] = round_sat(wext_p(r1_pm[0][0]) - wext_p(r1_pm[1][1])
                         - wext_p(r1_pm[2][2]) - wext_p(r1_pm[3][3]));
        ham[1] = round_sat(wext_p(r1_pm[0][1]) + wext_p(r1_pm[1][0])
                         + wext_p(r1_pm[2][3]) - wext_p(r1_pm[3][2]));
        ham[2] = round_sat(wext_p(r1_pm[0][2]) + wext_p(r1_pm[2][0])
                         + wext_p(r1_pm[3][1]) - wext_p(r1_pm[1][3]));
        ham[3] = round_sat(wext_p(r1_pm[0][3]) + wext_p(r1_pm[3][0])
                         + wext_p(r1_pm[1][2]) - wext_p(r1_pm[2][1]));
        c1s[0] = round_sat(wext_p(r1_pm[2][3]) - wext_p(r1_pm[3][2]));
        c1s[1] = round_sat(wext_p(r1_pm[3][1]) - wext_p(r1_pm[1][3]));
        c1s[2] = round_sat(wext_p(r1_pm[1][2]) - wext_p(r1_pm[2][1]));
        for (int k = 0; k < 4; k++) begin
            nq[k] = neg_sat(r1_qa[k]);
        end
        ssum = {2'b00, r1_sq[0]} + {2'b00, r1_sq[1]}
             + {2'b00, r1_sq[2]} + {2'b00, r1_sq[3]};
        lsq  = round_sat({{(WIDE_BITS-RAD_BITS){1'b0}}, ssum});

        n2_c.cmd  = r1_cmd;
        n2_c.zero = (ssum == '0);
        n2_c.s    = ssum;
        n2_c.res  = '0;
        n2_c.ovf  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n2_c.qa[k] = r1_qa[k];
            n2_c.qb[k] = r1_qb[k];
        end
        for (int k = 0; k < 3; k++) begin
            n2_c.c1[k] = c1s[k].val;
        end

        case (r1_cmd)
            CMD_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    n2_c.res[k] = ham[k].val;
                end
                n2_c.ovf = ham[0].ovf | ham[1].ovf | ham[2].ovf | ham[3].ovf;
            end
            CMD_ROT: begin
                n2_c.ovf = c1s[0].ovf | c1s[1].ovf | c1s[2].ovf;
            end
            CMD_CONJ: begin
                n2_c.res[0] = r1_qa[0];
                for (int k = 1; k < 4; k++) begin
                    n2_c.res[k] = nq[k].val;
                end
                n2_c.ovf = nq[1].ovf | nq[2].ovf | nq[3].ovf;
            end
            CMD_NEG: begin
                for (int k = 0; k < 4; k++) begin
                    n2_c.res[k] = nq[k].val;
                end
                n2_c.ovf = nq[0].ovf | nq[1].ovf | nq[2].ovf | nq[3].ovf;
            end
            CMD_LSQ: begin
                n2_c.res[0] = lsq.val;
                n2_c.ovf    = lsq.ovf;
            end
            default: begin
                n2_c.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_c <= n2_c;
        end
    end

    // Stage 3: products for the second cross product and the w * (q x v) term.
    logic   r3_valid;
    t_carry r3_c;
    t_prod  r3_pa [3];
    t_prod  r3_pb [3];
    t_prod  r3_pt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c     <= r2_c;
            r3_pa[0] <= $signed(r2_c.qa[2]) * $signed(r2_c.c1[2]);
            r3_pb[0] <= $signed(r2_c.qa[3]) * $signed(r2_c.c1[1]);
            r3_pa[1] <= $signed(r2_c.qa[3]) * $signed(r2_c.c1[0]);
            r3_pb[1] <= $signed(r2_c.qa[1]) * $signed(r2_c.c1[2]);
            r3_pa[2] <= $signed(r2_c.qa[1]) * $signed(r2_c.c1[1]);
            r3_pb[2] <= $signed(r2_c.qa[2]) * $signed(r2_c.c1[0]);
            for (int k = 0; k < 3; k++) begin
                r3_pt[k] <= $signed(r2_c.qa[0]) * $signed(r2_c.c1[k]);
            end
        end
    end

    // Stage 4: second cross product, rounded and saturated.
    t_sat   c2s [3];
    t_carry n4_c;
    t_carry r4_c;
    logic   r4_valid;
    t_data  r4_c2 [3];
    t_prod  r4_pt [3];

    always_comb begin
        n4_c = r3_c;
        for (int k = 0; k < 3; k++) begin
            c2s[k] = round_sat(wext_p(r3_pa[k]) - wext_p(r3_pb[k]));
        end
        if (r3_c.cmd == CMD_ROT) begin
            n4_c.ovf = r3_c.ovf | c2s[0].ovf | c2s[1].ovf | c2s[2].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c <= n4_c;
            for (int k = 0; k < 3; k++) begin
                r4_c2[k] <= c2s[k].val;
                r4_pt[k] <= r3_pt[k];
            end
        end
    end

    // Stage 5: rotation output terms; set up the root and divider fields.
    t_sat                 rot [3];
    logic [DATA_BITS-1:0] mag [4];
    t_item                n5_item;
    t_item                r5_item;
    logic                 r5_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rot[k] = round_sat(((wext_p(r4_pt[k]) + (wext_d(r4_c2[k]) <<< FRAC_BITS)) <<< 1)
                               + (wext_d(r4_c.qb[k+1]) <<< FRAC_BITS));
        end
        n5_item.cmd  = r4_c.cmd;
        n5_item.zero = r4_c.zero;
        n5_item.res  = r4_c.res;
        n5_item.ovf  = r4_c.ovf;
        if (r4_c.cmd == CMD_ROT) begin
            n5_item.res[0] = '0;
            for (int k = 0; k < 3; k++) begin
                n5_item.res[k+1] = rot[k].val;
            end
            n5_item.ovf = r4_c.ovf | rot[0].ovf | rot[1].ovf | rot[2].ovf;
        end
        n5_item.rad  = r4_c.s;
        n5_item.rem  = '0;
        n5_item.root = '0;
        for (int k = 0; k < 4; k++) begin
            n5_item.neg[k]  = r4_c.qa[k][DATA_BITS-1];
            mag[k]          = r4_c.qa[k][DATA_BITS-1] ? (~r4_c.qa[k] + 1'b1) : r4_c.qa[k];
            n5_item.drem[k] = {2'b00, mag[k][DATA_BITS-1:1]};
            n5_item.dq[k]   = {mag[k][0], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_item <= n5_item;
        end
    end

    assign o_valid = r5_valid;
    assign o_item  = r5_item;

endmodule

[hw/rtl/qau_sqrt_step.sv]
module qau_sqrt_step import qau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    // One bit of the digit-by-digit square root per stage.
    logic [ROOT_BITS+2:0] rem_ext;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] diff;
    t_item                n_item;
    t_item                r_item;
    logic                 r_valid;

    always_comb begin
        n_item  = i_item;
        rem_ext = {i_item.rem, i_item.rad[RAD_BITS-1 -: 2]};
        trial   = {1'b0, i_item.root, 2'b01};
        diff    = rem_ext - trial;
        n_item.rad = {i_item.rad[RAD_BITS-3:0], 2'b00};
        if (rem_ext >= trial) begin
            n_item.rem  = diff[ROOT_BITS:0];
            n_item.root = {i_item.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_item.rem  = rem_ext[ROOT_BITS:0];
            n_item.root = {i_item.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_item.rem <= {r_item.root, 1'b0})
        else $error("square root remainder exceeds twice the partial root");

endmodule

[hw/rtl/qau_div_step.sv]
module qau_div_step import qau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    // One restoring division bit per stage, four lanes sharing the length.
    logic [ROOT_BITS:0] len;
    logic [ROOT_BITS:0] part [4];
    logic [ROOT_BITS:0] diff [4];
    t_item              n_item;
    t_item              r_item;
    logic               r_valid;

    always_comb begin
        n_item = i_item;
        len    = {1'b0, i_item.root};
        for (int k = 0; k < 4; k++) begin
            part[k] = {i_item.drem[k], i_item.dq[k][QUO_BITS-1]};
            diff[k] = part[k] - len;
            if (part[k] >= len) begin
                n_item.drem[k] = diff[k][ROOT_BITS-1:0];
                n_item.dq[k]   = {i_item.dq[k][QUO_BITS-2:0], 1'b1};
            end else begin
                n_item.drem[k] = part[k][ROOT_BITS-1:0];
                n_item.dq[k]   = {i_item.dq[k][QUO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.cmd == CMD_NORM && !r_item.zero
        |-> r_item.drem[0] < r_item.root && r_item.drem[1] < r_item.root
         && r_item.drem[2] < r_item.root && r_item.drem[3] < r_item.root)
        else $error("normalize divider remainder not below the length");

endmodule

[hw/rtl/quaternion_arithmetic_unit_top.sv]
// Quaternion arithmetic unit, signed Q16.16 fixed point.
// Input channel: i_valid / o_ready carry one transaction with a command and
// the operands A (i_a_*) and B (i_b_*). Output channel: o_valid / i_ready
// carry one result transaction (o_r_*, o_status) for every input transaction,
// in order. Commands are product, vector rotation, normalize, conjugate,
// negate, length and squared length; lengths come back in o_r_w.
// The datapath is one pipeline: five arithmetic stages, one square-root stage
// per root bit (DATA_BITS + 1), one divider stage per quotient bit
// (FRAC_BITS + 1) and the output register. Every command passes through the
// same stages. A new transaction can be accepted every cycle unless the
// receiver stalls the pipeline; throughput is then one per clock.
// The stage count is set by the bit-serial root and the normalize divider.
// Reset (synchronous, active low) empties the pipeline by clearing all valid
// bits; o_valid drops and nothing in flight is delivered.
// When the receiver holds i_ready low while a result waits, the whole pipeline
// freezes in place and o_ready goes low; no transaction is dropped or repeated,
// and flow resumes in the cycle i_ready returns.
module quaternion_arithmetic_unit_top import qau_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_cmd,
    input  logic signed [DATA_BITS-1:0] i_a_w,
    input  logic signed [DATA_BITS-1:0] i_a_x,
    input  logic signed [DATA_BITS-1:0] i_a_y,
    input  logic signed [DATA_BITS-1:0] i_a_z,
    input  logic signed [DATA_BITS-1:0] i_b_w,
    input  logic signed [DATA_BITS-1:0] i_b_x,
    input  logic signed [DATA_BITS-1:0] i_b_y,
    input  logic signed [DATA_BITS-1:0] i_b_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [DATA_BITS-1:0] o_r_w,
    output logic signed [DATA_BITS-1:0] o_r_x,
    output logic signed [DATA_BITS-1:0] o_r_y,
    output logic signed [DATA_BITS-1:0] o_r_z,
    output logic [1:0]                  o_status
);

    // The pipeline moves as one: every stage advances unless a finished
    // result is sitting in the output register and the receiver is stalling.
    logic  pipe_en;
    t_data qa [4];
    t_data qb [4];

    assign pipe_en = !o_valid || i_ready;
    assign o_ready = pipe_en;

    assign qa[0] = i_a_w;
    assign qa[1] = i_a_x;
    assign qa[2] = i_a_y;
    assign qa[3] = i_a_z;
    assign qb[0] = i_b_w;
    assign qb[1] = i_b_x;
    assign qb[2] = i_b_y;
    assign qb[3] = i_b_z;

    // Products, sums, cross products and rotation terms.
    logic  fr_valid;
    t_item fr_item;

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_qa    (qa),
        .i_qb    (qb),
        .o_valid (fr_valid),
        .o_item  (fr_item)
    );

    // Square root of the sum of squares, one result bit per stage, most
    // significant first.
    logic  sq_valid [ROOT_BITS+1];
    t_item sq_item  [ROOT_BITS+1];

    assign sq_valid[0] = fr_valid;
    assign sq_item[0]  = fr_item;

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        qau_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (sq_valid[g]),
            .i_item  (sq_item[g]),
            .o_valid (sq_valid[g+1]),
            .o_item  (sq_item[g+1])
        );
    end

    // Normalize divides each |A_i| * 2^FRAC_BITS by the length. The quotient
    // never exceeds 2^FRAC_BITS, so only its low FRAC_BITS + 1 bits are formed.
    logic  dv_valid [QUO_BITS+1];
    t_item dv_item  [QUO_BITS+1];

    assign dv_valid[0] = sq_valid[ROOT_BITS];
    assign dv_item[0]  = sq_item[ROOT_BITS];

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
        qau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (dv_valid[g]),
            .i_item  (dv_item[g]),
            .o_valid (dv_valid[g+1]),
            .o_item  (dv_item[g+1])
        );
    end

    // Final selection: normalize and length take their values from the root
    // and divider fields; every other command already carries its result.
    t_item                fin;
    t_wide                qw [4];
    t_sat                 nv [4];
    t_sat                 lv;
    logic [3:0][DATA_BITS-1:0] n_res;
    logic                 n_ovf;
    logic [1:0]           n_status;

    assign fin = dv_item[QUO_BITS];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qw[k] = {{(WIDE_BITS-QUO_BITS){1'b0}}, fin.dq[k]};
            if (fin.neg[k]) begin
                qw[k] = -qw[k];
            end
            nv[k] = sat_wide(qw[k]);
        end
        lv = sat_wide({{(WIDE_BITS-ROOT_BITS){1'b0}}, fin.root});

        n_res = fin.res;
        n_ovf = fin.ovf;
        case (fin.cmd)
            CMD_NORM: begin
                if (fin.zero) begin
                    n_res = '0;
                    n_ovf = 1'b0;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        n_res[k] = nv[k].val;
                    end
                    n_ovf = nv[0].ovf | nv[1].ovf | nv[2].ovf | nv[3].ovf;
                end
            end
            CMD_LEN: begin
                n_res    = '0;
                n_res[0] = lv.val;
                n_ovf    = lv.ovf;
            end
            default: begin
                n_res = fin.res;
            end
        endcase

        if (fin.cmd == CMD_NORM && fin.zero) begin
            n_status = ST_ZERO;
        end else if (n_ovf) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    // Output register.
    logic                 r_out_valid;
    t_data                r_out_w;
    t_data                r_out_x;
    t_data                r_out_y;
    t_data                r_out_z;
    logic [1:0]           r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= dv_valid[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_w      <= n_res[0];
            r_out_x      <= n_res[1];
            r_out_y      <= n_res[2];
            r_out_z      <= n_res[3];
            r_out_status <= n_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_r_w    = r_out_w;
    assign o_r_x    = r_out_x;
    assign o_r_y    = r_out_y;
    assign o_r_z    = r_out_z;
    assign o_status = r_out_status;

    a_zero_norm_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO
        |-> o_r_w == '0 && o_r_x == '0 && o_r_y == '0 && o_r_z == '0)
        else $error("zero-length normalize delivered a nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'b11)
        else $error("result carries an undefined status");

endmodule
